// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions that are disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk.
`define KVI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk.
`define KVI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/kvi_pkg.sv
// ---------------------------------------------------------------------------
// kvi_pkg
// Shared types and constants of the keyframe vector interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package kvi_pkg;

  localparam int KVI_KEY_DEPTH = 64;
  localparam int KVI_TIME_W    = 32;
  localparam int KVI_DATA_W    = 32;
  localparam int KVI_FRAC_W    = 16;
  localparam int KVI_COUNT_W   = 7;
  localparam int KVI_INDEX_W   = 6;

  typedef enum logic {
    KVI_OP_WRITE = 1'b0,
    KVI_OP_QUERY = 1'b1
  } kvi_op_t;

  // One keyframe as it sits in the table.
  typedef struct packed {
    logic [KVI_TIME_W-1:0]        t;
    logic signed [KVI_DATA_W-1:0] x;
    logic signed [KVI_DATA_W-1:0] y;
    logic signed [KVI_DATA_W-1:0] z;
  } kvi_key_t;

endpackage

`default_nettype wire

// File: sv/kvi_if.sv
// ---------------------------------------------------------------------------
// kvi channel interfaces
// Valid/ready channels for requests, results and the key count register.
// ---------------------------------------------------------------------------
`default_nettype none

interface kvi_req_if import kvi_pkg::*; ();
  logic                         valid;
  logic                         ready;
  kvi_op_t                      op;
  logic [KVI_INDEX_W-1:0]       entry_index;
  logic [KVI_TIME_W-1:0]        time_value;
  logic signed [KVI_DATA_W-1:0] in_x;
  logic signed [KVI_DATA_W-1:0] in_y;
  logic signed [KVI_DATA_W-1:0] in_z;

  modport source (output valid, op, entry_index, time_value, in_x, in_y, in_z,
                  input ready);
  modport sink (input valid, op, entry_index, time_value, in_x, in_y, in_z,
                output ready);
endinterface

interface kvi_rsp_if import kvi_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [KVI_DATA_W-1:0] out_x;
  logic signed [KVI_DATA_W-1:0] out_y;
  logic signed [KVI_DATA_W-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

interface kvi_cfg_if import kvi_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [KVI_COUNT_W-1:0] key_count;

  modport source (output valid, key_count, input ready);
  modport sink (input valid, key_count, output ready);
endinterface

`default_nettype wire

// File: sv/keyframe_vector_interpolator.sv
// ---------------------------------------------------------------------------
// keyframe_vector_interpolator
// Piecewise linear interpolation of an x,y,z vector over a keyframe table.
// ---------------------------------------------------------------------------
// Usage. Requests arrive on req. A write request stores the key time and
// vector at entry_index; it gives no result. A query request carries a
// sample time and returns one vector on rsp. cfg sets key_count, the
// number of entries in use; it is always ready and must be written only
// while no query is in flight.
// Operation. A query first reads key 0 and then walks the table one key at
// a time, bound by the single read port of the key store. Times at or
// before key 0, a single key or a time past every pair skip the
// arithmetic. A bracketed time also runs the bit-serial divider and then
// the serial blend lanes.
// Only one query is worked on at a time; req is ready whenever the
// sequencer is idle.
// Reset clears the sequencer, drops rsp.valid and sets key_count to 1. The
// table is not cleared, so entries must be written before they are queried.
// When the receiver stalls, a finished result is held on rsp and new
// requests are still taken; a following query waits at its end until the
// held result has been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_vector_interpolator import kvi_pkg::*; #(
  parameter int KEY_DEPTH = KVI_KEY_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  kvi_req_if.sink    req,
  kvi_rsp_if.source  rsp,
  kvi_cfg_if.sink    cfg
);

  `include "assert_macros.svh"

  localparam int AW    = $clog2(KEY_DEPTH);
  // Index width wide enough for both the request field and the depth itself.
  localparam int IW    = ((AW + 1) > KVI_INDEX_W) ? (AW + 1) : KVI_INDEX_W;
  localparam int CW    = ((AW + 1) > KVI_COUNT_W) ? (AW + 1) : KVI_COUNT_W;
  localparam logic [KVI_FRAC_W:0] FRAC_ONE = {1'b1, {KVI_FRAC_W{1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_STEP  = 6'b000100,
    S_DIV   = 6'b001000,
    S_MUL   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [KVI_COUNT_W-1:0]       key_count;
  logic [KVI_TIME_W-1:0]        tv;
  kvi_key_t                     prev;
  kvi_key_t                     seg_a;
  kvi_key_t                     seg_b;
  logic [AW-1:0]                nxt;
  logic signed [KVI_DATA_W-1:0] res_x;
  logic signed [KVI_DATA_W-1:0] res_y;
  logic signed [KVI_DATA_W-1:0] res_z;

  logic                         req_fire;
  logic                         out_free;
  logic [IW-1:0]                idx_ext;
  logic                         wr_en;
  kvi_key_t                     wr_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  kvi_key_t                     rd_data;
  logic [CW-1:0]                kc_ext;
  logic [CW-1:0]                n_eff;
  logic [CW-1:0]                n_last;
  logic [AW-1:0]                last;
  logic                         single;
  logic                         in_seg;

  logic                         div_start;
  logic                         div_busy;
  logic [KVI_FRAC_W:0]          div_quot;
  logic                         mul_start;
  logic                         busy_x;
  logic                         busy_y;
  logic                         busy_z;
  logic signed [KVI_DATA_W-1:0] lane_x;
  logic signed [KVI_DATA_W-1:0] lane_y;
  logic signed [KVI_DATA_W-1:0] lane_z;

  // Handshakes. The register port never back-pressures; requests are taken
  // whenever the sequencer is idle.
  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= KVI_COUNT_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      key_count <= cfg.key_count;
    end
  end

  // A count of zero behaves as one, and a count above the depth saturates.
  assign kc_ext = CW'(key_count);
  always_comb begin
    if (kc_ext == '0) begin
      n_eff = CW'(1);
    end else if (kc_ext > CW'(KEY_DEPTH)) begin
      n_eff = CW'(KEY_DEPTH);
    end else begin
      n_eff = kc_ext;
    end
  end
  assign n_last = n_eff - CW'(1);
  assign last   = n_last[AW-1:0];
  assign single = (n_eff == CW'(1));

  // Writes beyond the depth are dropped.
  assign idx_ext   = IW'(req.entry_index);
  assign wr_en     = req_fire && (req.op == KVI_OP_WRITE) && (idx_ext < IW'(KEY_DEPTH));
  assign wr_data.t = req.time_value;
  assign wr_data.x = req.in_x;
  assign wr_data.y = req.in_y;
  assign wr_data.z = req.in_z;

  kvi_key_store #(
    .DEPTH (KEY_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The current pair is the previous key and the one just read.
  assign in_seg = (tv >= prev.t) && (tv <= rd_data.t);

  // Sequencer. Reads are registered, so each key of the walk
  // is examined in the cycle after its address is presented.
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = '0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_fire && (req.op == KVI_OP_QUERY)) begin
          rd_en      = 1'b1;
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        if (single || (tv <= rd_data.t)) begin
          state_next = S_OUT;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = AW'(1);
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (in_seg) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else if (nxt == last) begin
          state_next = S_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = nxt + AW'(1);
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (!busy_x) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers. The result registers follow the last key read, so a
  // walk that ends without a bracketing pair already holds the last key.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      tv <= req.time_value;
    end
    if (state == S_FIRST) begin
      prev  <= rd_data;
      nxt   <= AW'(1);
      res_x <= rd_data.x;
      res_y <= rd_data.y;
      res_z <= rd_data.z;
    end
    if (state == S_STEP) begin
      prev  <= rd_data;
      seg_a <= prev;
      seg_b <= rd_data;
      nxt   <= nxt + AW'(1);
      res_x <= rd_data.x;
      res_y <= rd_data.y;
      res_z <= rd_data.z;
    end
    if ((state == S_MUL) && !busy_x) begin
      res_x <= lane_x;
      res_y <= lane_y;
      res_z <= lane_z;
    end
  end

  kvi_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .offset (tv - prev.t),
    .span   (rd_data.t - prev.t),
    .busy   (div_busy),
    .quot   (div_quot)
  );

  kvi_blend_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (seg_a.x),
    .b      (seg_b.x),
    .frac   (div_quot),
    .busy   (busy_x),
    .result (lane_x)
  );

  kvi_blend_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (seg_a.y),
    .b      (seg_b.y),
    .frac   (div_quot),
    .busy   (busy_y),
    .result (lane_y)
  );

  kvi_blend_lane u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (seg_a.z),
    .b      (seg_b.z),
    .frac   (div_quot),
    .busy   (busy_z),
    .result (lane_z)
  );

  // Output register: loaded once the previous result has been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && out_free) begin
      rsp.out_x <= res_x;
      rsp.out_y <= res_y;
      rsp.out_z <= res_z;
    end
  end

  // The walk never runs past the last key in use.
  `KVI_ASSERT_IMP(a_walk_in_range, state == S_STEP, (nxt <= last) && (nxt != '0), "key walk past last key")
  // The blend lanes run together and the fraction never exceeds one.
  `KVI_ASSERT_IMP(a_lanes_agree, state == S_MUL, (busy_x == busy_y) && (busy_x == busy_z) && (div_quot <= FRAC_ONE), "blend lanes out of step or fraction above one")
  // Starting the blend always sets the lanes running.
  `KVI_ASSERT_NXT(a_blend_starts, mul_start, busy_x && !div_busy, "blend lanes failed to start")

endmodule

`default_nettype wire

// File: sv/kvi_key_store.sv
// ---------------------------------------------------------------------------
// kvi_key_store
// Keyframe table: one write port and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module kvi_key_store import kvi_pkg::*; #(
  parameter int DEPTH = KVI_KEY_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  kvi_key_t      wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output kvi_key_t      rd_data
);

  kvi_key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: sv/kvi_divider.sv
// ---------------------------------------------------------------------------
// kvi_divider
// Restoring divider giving the span fraction one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module kvi_divider import kvi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [KVI_TIME_W-1:0] offset,
  input  logic [KVI_TIME_W-1:0] span,
  output logic                  busy,
  output logic [KVI_FRAC_W:0]   quot
);

  localparam int QW    = KVI_FRAC_W + 1;
  localparam int CNT_W = $clog2(QW + 1);

  // The offset never exceeds the span, so the quotient fits in QW bits and
  // the partial remainder never needs more than one bit above the span.
  logic [KVI_TIME_W:0]   rem;
  logic [KVI_TIME_W-1:0] dvs;
  logic [QW-1:0]         q;
  logic [CNT_W-1:0]      cnt;
  logic                  zero_span;
  logic [KVI_TIME_W+1:0] diff;
  logic                  ge;

  assign diff = {1'b0, rem} - {2'b00, dvs};
  assign ge   = ~diff[KVI_TIME_W+1];
  assign quot = zero_span ? '0 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(QW - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem       <= {1'b0, offset};
      dvs       <= span;
      zero_span <= (span == '0);
      q         <= '0;
    end else if (busy) begin
      q   <= {q[QW-2:0], ge};
      rem <= ge ? {diff[KVI_TIME_W-1:0], 1'b0} : {rem[KVI_TIME_W-1:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// File: sv/kvi_blend_lane.sv
// ---------------------------------------------------------------------------
// kvi_blend_lane
// Serial blend of one component: a + floor((b - a) * f / 2^16).
// ---------------------------------------------------------------------------
`default_nettype none

module kvi_blend_lane import kvi_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [KVI_DATA_W-1:0] a,
  input  logic signed [KVI_DATA_W-1:0] b,
  input  logic [KVI_FRAC_W:0]          frac,
  output logic                         busy,
  output logic signed [KVI_DATA_W-1:0] result
);

  localparam int QW    = KVI_FRAC_W + 1;
  localparam int DW    = KVI_DATA_W + 1;
  localparam int ACC_W = KVI_DATA_W + 3;
  localparam int CNT_W = $clog2(QW + 1);

  // The fraction is consumed from its least significant bit. Each of the
  // first sixteen partial sums is halved with an arithmetic shift, which
  // floors exactly; the top bit carries unit weight and is added unshifted.
  // A final step adds the start value.
  logic signed [KVI_DATA_W-1:0] base;
  logic signed [DW-1:0]         dlt;
  logic [QW-1:0]                f;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      addend;
  logic signed [ACC_W-1:0]      sum;
  logic [CNT_W-1:0]             cnt;

  assign addend = f[0] ? ACC_W'(dlt) : '0;
  assign sum    = acc + addend;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(QW)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base <= a;
      dlt  <= DW'(b) - DW'(a);
      f    <= frac;
      acc  <= '0;
    end else if (busy) begin
      if (cnt < CNT_W'(QW - 1)) begin
        acc <= sum >>> 1;
        f   <= f >> 1;
      end else if (cnt == CNT_W'(QW - 1)) begin
        acc <= sum;
      end else begin
        result <= base + acc[KVI_DATA_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire
